// ===== sv/scaled_glyph_row_expander_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Scaled glyph row expander assertion macros
// Concurrent assertion wrappers clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_ROW_EXPANDER_UNIT_MACROS_SVH
`define SCALED_GLYPH_ROW_EXPANDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define SGRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Property whose consequent must hold in the cycle after its antecedent.
`define SGRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SGRE_ASSERT(lbl, prop, msg)
`define SGRE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/sgre_pkg.sv =====
// ----------------------------------------------------------------------------
// Scaled glyph row expander package
// Field widths, parameter defaults, register codes and the config struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sgre_pkg;

    // Parameter defaults.
    localparam int GLYPH_WIDTH_DEF  = 8;
    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int MAX_SCALE_DEF    = 4;
    localparam int ADDR_BITS_DEF    = 24;

    // Fixed field widths.
    localparam int ROW_W      = 8;
    localparam int ROW_IDX_W  = 4;
    localparam int ORIGIN_W   = 12;
    localparam int MASK_W     = 32;
    localparam int LINE_W     = 13;
    localparam int LINE_NUM_W = 13;
    localparam int SCALE_W    = 3;
    localparam int COLOR_W    = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FG_COLOR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BG_COLOR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BG_ENABLE  = 3'd4;

    // Register reset values.
    localparam logic [LINE_W-1:0]  LINE_WIDTH_RST = 13'd640;
    localparam logic [SCALE_W-1:0] SCALE_RST      = 3'd1;
    localparam logic [COLOR_W-1:0] FG_COLOR_RST   = 8'd255;
    localparam logic [COLOR_W-1:0] BG_COLOR_RST   = 8'd0;

    // Configuration register set.
    typedef struct packed {
        logic [LINE_W-1:0]  line_width;
        logic [SCALE_W-1:0] scale;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               bg_enable;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/sgre_front.sv =====
// ----------------------------------------------------------------------------
// Glyph row front end
// Accepts rows, drops rows outside the glyph, widens the masks and forms
// the start address of the first output line.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scaled_glyph_row_expander_unit_macros.svh"

module sgre_front #(
    parameter int GLYPH_WIDTH  = sgre_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = sgre_pkg::GLYPH_HEIGHT_DEF,
    parameter int MAX_SCALE    = sgre_pkg::MAX_SCALE_DEF,
    parameter int ADDR_BITS    = sgre_pkg::ADDR_BITS_DEF,
    parameter int CNT_W        = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  sgre_pkg::t_cfg                i_cfg,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [sgre_pkg::ROW_W-1:0]          i_glyph_row,
    input  wire  [sgre_pkg::ROW_IDX_W-1:0]      i_row_index,
    input  wire  [sgre_pkg::ORIGIN_W-1:0]       i_origin_x,
    input  wire  [sgre_pkg::ORIGIN_W-1:0]       i_origin_y,
    output logic                                o_ent_valid,
    input  wire                                 i_ent_ready,
    output logic [ADDR_BITS-1:0]                o_addr,
    output logic [sgre_pkg::MASK_W-1:0]         o_fg,
    output logic [sgre_pkg::MASK_W-1:0]         o_bg,
    output logic [CNT_W-1:0]                    o_cnt
);

    localparam int PROD_W = 2 * sgre_pkg::LINE_W;
    localparam int SUM_W  = (ADDR_BITS > PROD_W + 1) ? ADDR_BITS : PROD_W + 1;
    localparam int RS_W   = sgre_pkg::ROW_IDX_W + sgre_pkg::SCALE_W;

    logic [sgre_pkg::SCALE_W-1:0]    w_scale;
    logic [CNT_W-1:0]                w_s_last;
    logic [RS_W-1:0]                 w_row_scaled;
    logic [sgre_pkg::LINE_NUM_W-1:0] w_line0;
    logic                            w_row_ok;
    logic                            w_accept;
    logic                            w_push;
    logic [sgre_pkg::MASK_W-1:0]     w_fg_by_s   [MAX_SCALE];
    logic [sgre_pkg::MASK_W-1:0]     w_cell_by_s [MAX_SCALE];
    logic [sgre_pkg::MASK_W-1:0]     w_fg;
    logic [sgre_pkg::MASK_W-1:0]     w_bg;
    logic [PROD_W-1:0]               w_prod;
    logic [SUM_W-1:0]                w_sum;

    logic                            r_valid;
    logic [sgre_pkg::LINE_NUM_W-1:0] r_line0;
    logic [sgre_pkg::ORIGIN_W-1:0]   r_ox;
    logic [sgre_pkg::MASK_W-1:0]     r_fg;
    logic [sgre_pkg::MASK_W-1:0]     r_bg;
    logic [CNT_W-1:0]                r_cnt;

    // Effective scale: zero acts as one, values above the maximum are clamped.
    always_comb begin
        if (i_cfg.scale == '0) begin
            w_scale = 3'd1;
        end else if (i_cfg.scale > 3'(MAX_SCALE)) begin
            w_scale = 3'(MAX_SCALE);
        end else begin
            w_scale = i_cfg.scale;
        end
    end
    assign w_s_last = CNT_W'(w_scale - 3'd1);

    // Rows at or beyond the glyph height produce no output lines.
    assign w_row_ok = ({1'b0, i_row_index} < 5'(GLYPH_HEIGHT));

    // First framebuffer line of this row.
    assign w_row_scaled = RS_W'(i_row_index) * RS_W'(w_scale);
    assign w_line0 = sgre_pkg::LINE_NUM_W'(i_origin_y) + sgre_pkg::LINE_NUM_W'(w_row_scaled);

    // Widened glyph and cell masks for each supported scale.
    always_comb begin
        for (int sc = 1; sc <= MAX_SCALE; sc++) begin
            w_fg_by_s[sc-1]   = '0;
            w_cell_by_s[sc-1] = '0;
            for (int col = 0; col < GLYPH_WIDTH; col++) begin
                for (int l = 0; l < sc; l++) begin
                    w_fg_by_s[sc-1][col*sc+l]   = i_glyph_row[sgre_pkg::ROW_W-1-col];
                    w_cell_by_s[sc-1][col*sc+l] = 1'b1;
                end
            end
        end
    end
    assign w_fg = w_fg_by_s[w_s_last];
    assign w_bg = i_cfg.bg_enable ? (w_cell_by_s[w_s_last] & ~w_fg) : '0;

    // Handshakes.
    assign o_ready  = !r_valid || i_ent_ready;
    assign w_accept = i_valid && o_ready;
    assign w_push   = r_valid && i_ent_ready;

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_row_ok;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line0 <= w_line0;
            r_ox    <= i_origin_x;
            r_fg    <= w_fg;
            r_bg    <= w_bg;
            r_cnt   <= w_s_last;
        end
    end

    // Start address of the first line: line * stride + column.
    assign w_prod = PROD_W'(r_line0) * PROD_W'(i_cfg.line_width);
    assign w_sum  = SUM_W'(w_prod) + SUM_W'(r_ox);

    assign o_ent_valid = r_valid;
    assign o_addr      = w_sum[ADDR_BITS-1:0];
    assign o_fg        = r_fg;
    assign o_bg        = r_bg;
    assign o_cnt       = r_cnt;

    `SGRE_ASSERT_NEXT(a_drop_row, w_accept && !w_row_ok, !r_valid,
        "row outside the glyph was queued")

endmodule

`default_nettype wire

// ===== sv/sgre_fifo.sv =====
// ----------------------------------------------------------------------------
// Glyph row queue
// Short register queue that decouples the front end from the line emitter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scaled_glyph_row_expander_unit_macros.svh"

module sgre_fifo #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = sgre_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  wire  [DATA_W-1:0]   i_push_data,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output logic [DATA_W-1:0]   o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr;
    logic [PTR_W-1:0]  n_rd;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointer wrap.
    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    `SGRE_ASSERT(a_count_range, r_count <= CNT_W'(DEPTH),
        "queue fill count beyond depth")

endmodule

`default_nettype wire

// ===== sv/sgre_back.sv =====
// ----------------------------------------------------------------------------
// Glyph line emitter
// Takes queued rows and emits one framebuffer line per cycle while the
// receiver is ready, stepping the address by the line stride.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scaled_glyph_row_expander_unit_macros.svh"

module sgre_back #(
    parameter int ADDR_BITS = sgre_pkg::ADDR_BITS_DEF,
    parameter int CNT_W     = 2
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  sgre_pkg::t_cfg          i_cfg,
    input  wire                           i_ent_valid,
    output logic                          o_ent_ready,
    input  wire  [ADDR_BITS-1:0]          i_addr,
    input  wire  [sgre_pkg::MASK_W-1:0]   i_fg,
    input  wire  [sgre_pkg::MASK_W-1:0]   i_bg,
    input  wire  [CNT_W-1:0]              i_cnt,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [ADDR_BITS-1:0]          o_line_address,
    output logic [sgre_pkg::MASK_W-1:0]   o_fg_mask,
    output logic [sgre_pkg::MASK_W-1:0]   o_bg_mask,
    output logic                          o_last
);

    logic                          r_valid;
    logic [ADDR_BITS-1:0]          r_addr;
    logic [sgre_pkg::MASK_W-1:0]   r_fg;
    logic [sgre_pkg::MASK_W-1:0]   r_bg;
    logic [CNT_W-1:0]              r_left;
    logic                          w_last;

    // A new row is taken when idle or when the final line leaves.
    assign w_last      = (r_left == '0);
    assign o_ent_ready = !r_valid || (i_ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ent_ready) begin
            r_valid <= i_ent_valid;
        end
    end

    // Load a row, or step to the next line of the current one.
    always_ff @(posedge i_clk) begin
        if (o_ent_ready) begin
            r_addr <= i_addr;
            r_fg   <= i_fg;
            r_bg   <= i_bg;
            r_left <= i_cnt;
        end else if (i_ready) begin
            r_addr <= r_addr + ADDR_BITS'(i_cfg.line_width);
            r_left <= r_left - 1'b1;
        end
    end

    assign o_valid        = r_valid;
    assign o_line_address = r_addr;
    assign o_fg_mask      = r_fg;
    assign o_bg_mask      = r_bg;
    assign o_last         = w_last;

    `SGRE_ASSERT_NEXT(a_line_step, r_valid && i_ready && !w_last,
        r_valid && (r_left == CNT_W'($past(r_left) - 1'b1)),
        "line countdown did not advance")
    `SGRE_ASSERT_NEXT(a_drain_idle, r_valid && i_ready && w_last && !i_ent_valid,
        !r_valid, "emitter stayed valid after its final line")

endmodule

`default_nettype wire

// ===== sv/scaled_glyph_row_expander_unit.sv =====
// ----------------------------------------------------------------------------
// Scaled glyph row expander
// Turns glyph rows into scaled framebuffer line writes with fg/bg masks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one glyph row, its row index and
//   the cell origin per transaction. Output channel (o_valid/i_ready) carries
//   one line write per transaction: start address, foreground mask,
//   background mask and a last flag on the final line of the row.
//   Each accepted row yields scale line writes (1 to 4); a row index at or
//   beyond the glyph height yields none.
//   An accepted row passes the front stage, the queue and the emitter register
//   before its first line appears on o_valid.
//   The emitter gives one line per cycle while the receiver is ready; the
//   front end takes a new row every cycle while the queue has room.
//   A stalled receiver holds the current line; the two-entry queue and the
//   front stage keep taking rows until full, then o_ready drops.
//   Reset clears all pipeline state and loads the register defaults (stride 640,
//   scale 1, fg 255, bg 0, background fill off). Registers must be written over
//   the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_glyph_row_expander_unit #(
    parameter int GLYPH_WIDTH  = sgre_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = sgre_pkg::GLYPH_HEIGHT_DEF,
    parameter int MAX_SCALE    = sgre_pkg::MAX_SCALE_DEF,
    parameter int ADDR_BITS    = sgre_pkg::ADDR_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // APB configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [sgre_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [sgre_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sgre_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // Row input
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [sgre_pkg::ROW_W-1:0]       i_glyph_row,
    input  wire  [sgre_pkg::ROW_IDX_W-1:0]   i_row_index,
    input  wire  [sgre_pkg::ORIGIN_W-1:0]    i_origin_x,
    input  wire  [sgre_pkg::ORIGIN_W-1:0]    i_origin_y,
    // Line output
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [ADDR_BITS-1:0]             o_line_address,
    output logic [sgre_pkg::MASK_W-1:0]      o_fg_mask,
    output logic [sgre_pkg::MASK_W-1:0]      o_bg_mask,
    output logic                             o_last
);

    localparam int CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int ENT_W = ADDR_BITS + 2 * sgre_pkg::MASK_W + CNT_W;

    sgre_pkg::t_cfg                   r_cfg;
    logic [sgre_pkg::REG_IDX_W-1:0]   w_reg_idx;
    logic                             w_wr;

    logic                             w_f_valid;
    logic                             w_f_ready;
    logic [ADDR_BITS-1:0]             w_f_addr;
    logic [sgre_pkg::MASK_W-1:0]      w_f_fg;
    logic [sgre_pkg::MASK_W-1:0]      w_f_bg;
    logic [CNT_W-1:0]                 w_f_cnt;

    logic                             w_q_valid;
    logic                             w_q_ready;
    logic [ENT_W-1:0]                 w_q_data;
    logic [ADDR_BITS-1:0]             w_q_addr;
    logic [sgre_pkg::MASK_W-1:0]      w_q_fg;
    logic [sgre_pkg::MASK_W-1:0]      w_q_bg;
    logic [CNT_W-1:0]                 w_q_cnt;

    // Configuration registers.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[sgre_pkg::APB_ADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width <= sgre_pkg::LINE_WIDTH_RST;
            r_cfg.scale      <= sgre_pkg::SCALE_RST;
            r_cfg.fg_color   <= sgre_pkg::FG_COLOR_RST;
            r_cfg.bg_color   <= sgre_pkg::BG_COLOR_RST;
            r_cfg.bg_enable  <= 1'b0;
        end else if (w_wr) begin
            case (w_reg_idx)
                sgre_pkg::REG_LINE_WIDTH: begin
                    r_cfg.line_width <= pwdata[sgre_pkg::LINE_W-1:0];
                end
                sgre_pkg::REG_SCALE: begin
                    r_cfg.scale <= pwdata[sgre_pkg::SCALE_W-1:0];
                end
                sgre_pkg::REG_FG_COLOR: begin
                    r_cfg.fg_color <= pwdata[sgre_pkg::COLOR_W-1:0];
                end
                sgre_pkg::REG_BG_COLOR: begin
                    r_cfg.bg_color <= pwdata[sgre_pkg::COLOR_W-1:0];
                end
                sgre_pkg::REG_BG_ENABLE: begin
                    r_cfg.bg_enable <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (w_reg_idx)
            sgre_pkg::REG_LINE_WIDTH: prdata = sgre_pkg::APB_DATA_W'(r_cfg.line_width);
            sgre_pkg::REG_SCALE:      prdata = sgre_pkg::APB_DATA_W'(r_cfg.scale);
            sgre_pkg::REG_FG_COLOR:   prdata = sgre_pkg::APB_DATA_W'(r_cfg.fg_color);
            sgre_pkg::REG_BG_COLOR:   prdata = sgre_pkg::APB_DATA_W'(r_cfg.bg_color);
            sgre_pkg::REG_BG_ENABLE:  prdata = sgre_pkg::APB_DATA_W'(r_cfg.bg_enable);
            default:                  prdata = '0;
        endcase
    end

    // Front end: accept and classify rows.
    sgre_front #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .MAX_SCALE    (MAX_SCALE),
        .ADDR_BITS    (ADDR_BITS),
        .CNT_W        (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_glyph_row (i_glyph_row),
        .i_row_index (i_row_index),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .o_ent_valid (w_f_valid),
        .i_ent_ready (w_f_ready),
        .o_addr      (w_f_addr),
        .o_fg        (w_f_fg),
        .o_bg        (w_f_bg),
        .o_cnt       (w_f_cnt)
    );

    // Queue between front end and emitter.
    sgre_fifo #(
        .DATA_W (ENT_W),
        .DEPTH  (sgre_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  ({w_f_addr, w_f_fg, w_f_bg, w_f_cnt}),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_data)
    );

    assign {w_q_addr, w_q_fg, w_q_bg, w_q_cnt} = w_q_data;

    // Line emitter.
    sgre_back #(
        .ADDR_BITS (ADDR_BITS),
        .CNT_W     (CNT_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_ent_valid    (w_q_valid),
        .o_ent_ready    (w_q_ready),
        .i_addr         (w_q_addr),
        .i_fg           (w_q_fg),
        .i_bg           (w_q_bg),
        .i_cnt          (w_q_cnt),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_line_address (o_line_address),
        .o_fg_mask      (o_fg_mask),
        .o_bg_mask      (o_bg_mask),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
